// ===== design/bolq_pkg.sv =====
// Shared constants, codes and types of the bounded ordered list queue.
package bolq_pkg;

	// List storage
	localparam int DEPTH  = 4;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int OCC_W  = $clog2(DEPTH + 1);

	// Field widths
	localparam int VAL_W = 32;
	localparam int OP_W  = 3;
	localparam int ST_W  = 3;
	localparam int CNT_W = 3;
	localparam int CAP_W = 3;
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

	// Command queue between the front and the back (depth must be a power of two)
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// Operation codes
	localparam logic [OP_W-1:0] OP_ENQUEUE    = OP_W'(0);
	localparam logic [OP_W-1:0] OP_DEQUEUE    = OP_W'(1);
	localparam logic [OP_W-1:0] OP_INS_AFTER  = OP_W'(2);
	localparam logic [OP_W-1:0] OP_INS_BEFORE = OP_W'(3);
	localparam logic [OP_W-1:0] OP_DEL_AFTER  = OP_W'(4);
	localparam logic [OP_W-1:0] OP_DEL_BEFORE = OP_W'(5);

	// Status codes
	localparam logic [ST_W-1:0] ST_OK       = ST_W'(0);
	localparam logic [ST_W-1:0] ST_FULL     = ST_W'(1);
	localparam logic [ST_W-1:0] ST_EMPTY    = ST_W'(2);
	localparam logic [ST_W-1:0] ST_NOTFOUND = ST_W'(3);
	localparam logic [ST_W-1:0] ST_NONEIGH  = ST_W'(4);

	// Command classes produced by the front
	typedef enum logic [2:0] {
		K_NOP,
		K_ENQ,
		K_DEQ,
		K_INS,
		K_DEL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic                    after;
		logic signed [VAL_W-1:0] key_value;
		logic signed [VAL_W-1:0] ins_value;
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_OPEN_RD,
		S_OPEN_WR,
		S_CLOSE_RD0,
		S_CLOSE_CAP,
		S_CLOSE_RD,
		S_CLOSE_WR,
		S_RESP
	} back_state_t;

endpackage

// ===== design/bounded_ordered_list_queue.sv =====
// Top level of the bounded ordered list queue.
//
// Keeps an ordered list of up to DEPTH signed 32-bit values, front first.
// Request channel (in_valid/in_ready): operation, operand_value, new_value.
// Result channel (out_valid/out_ready): status, removed_value, entry_count,
// one result beat for every request beat, in request order.
// Configuration channel (cfg_valid/cfg_ready): capacity_limit, always ready;
// write it only while no request is outstanding.
// A request beat enters a two-entry command queue and is executed by the list
// sequencer, which reaches the list through one memory read and one write port.
// Enqueue, dequeue and rejected requests need no search; for the others a
// search compares the entries from the front one at a time, and opening or
// closing a slot then moves the entries behind it one at a time. With DEPTH 4
// a delete before a rear target is among the longest requests.
// Requests are executed one at a time, each starting the cycle after the
// previous result is loaded; the queue takes new beats meanwhile.
// Reset empties the list and the command queue and sets the capacity to 4;
// the list memory needs no clearing pass.
// When the receiver stalls the result beat is held in its output register,
// the next request is executed and then waits for that register to free.
module bounded_ordered_list_queue import bolq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CAP_W-1:0]        capacity_limit,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         operation,
	input  logic signed [VAL_W-1:0] operand_value,
	input  logic signed [VAL_W-1:0] new_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ST_W-1:0]         status,
	output logic signed [VAL_W-1:0] removed_value,
	output logic [CNT_W-1:0]        entry_count
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// Request decode and command queue.
	bolq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.operand_value (operand_value),
		.new_value     (new_value),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	// List storage and sequencer.
	bolq_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_limit (capacity_limit),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.removed_value  (removed_value),
		.entry_count    (entry_count)
	);

`ifndef SYNTHESIS
	// A removed value only comes with a successful operation.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (removed_value != '0) |-> (status == ST_OK))
		else $error("removed value reported with a failing status");

	// An empty report means the list held nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (entry_count == '0))
		else $error("empty status with a non-zero entry count");

	// A no-neighbour report needs at least one entry left in the list.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NONEIGH) |-> (entry_count != '0))
		else $error("no-neighbour status with an empty list");
`endif

endmodule

// ===== design/bolq_front.sv =====
// Front end: accepts request beats, classifies them and queues the commands.
module bolq_front import bolq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         operation,
	input  logic signed [VAL_W-1:0] operand_value,
	input  logic signed [VAL_W-1:0] new_value,
	output logic                    cmd_valid,
	input  logic                    cmd_ready,
	output cmd_t                    cmd
);

	cmd_t                cmd_in;
	cmd_t                fifo_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] count_q;
	logic                push;
	logic                pop;

	// Decode the operation code into a command class and a side flag.
	always_comb begin
		cmd_in.key_value = operand_value;
		cmd_in.ins_value = new_value;
		cmd_in.after     = 1'b0;
		case (operation)
			OP_ENQUEUE: begin
				cmd_in.kind = K_ENQ;
			end
			OP_DEQUEUE: begin
				cmd_in.kind = K_DEQ;
			end
			OP_INS_AFTER: begin
				cmd_in.kind  = K_INS;
				cmd_in.after = 1'b1;
			end
			OP_INS_BEFORE: begin
				cmd_in.kind = K_INS;
			end
			OP_DEL_AFTER: begin
				cmd_in.kind  = K_DEL;
				cmd_in.after = 1'b1;
			end
			OP_DEL_BEFORE: begin
				cmd_in.kind = K_DEL;
			end
			default: begin
				cmd_in.kind = K_NOP;
			end
		endcase
	end

	// Queue handshakes.
	assign in_ready  = (count_q != CQ_CNT_W'(CQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Queue pointers and fill count; pointers wrap as the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// ===== design/bolq_back.sv =====
// Back end: holds the list and carries out one queued command at a time.
module bolq_back import bolq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CAP_W-1:0]        capacity_limit,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  cmd_t                    cmd,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ST_W-1:0]         status,
	output logic signed [VAL_W-1:0] removed_value,
	output logic [CNT_W-1:0]        entry_count
);

	back_state_t             state_q;
	back_state_t             state_d;
	cmd_t                    cmd_q;
	logic [CAP_W-1:0]        cap_q;
	logic [OCC_W-1:0]        occ_q;
	logic [OCC_W-1:0]        idx_q;
	logic [OCC_W-1:0]        slot_q;
	logic [ST_W-1:0]         status_q;
	logic signed [VAL_W-1:0] removed_q;
	logic [VAL_W-1:0]        mem_q [DEPTH];
	logic [VAL_W-1:0]        rdata_q;
	logic                    out_valid_q;
	logic [ST_W-1:0]         out_status_q;
	logic signed [VAL_W-1:0] out_removed_q;
	logic [CNT_W-1:0]        out_count_q;

	logic                    mem_re;
	logic [ADDR_W-1:0]       mem_raddr;
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_waddr;
	logic [VAL_W-1:0]        mem_wdata;
	logic                    out_load;

	logic [OCC_W-1:0]        idx_inc;
	logic [OCC_W-1:0]        idx_dec;
	logic                    full;
	logic                    empty;
	logic                    scan_end;
	logic                    hit;
	logic                    at_rear;
	logic                    del_noneigh;
	logic                    open_end;

	// Conditions shared by the sequencer and the datapath.
	assign idx_inc     = idx_q + 1'b1;
	assign idx_dec     = idx_q - 1'b1;
	assign full        = (CMP_W'(occ_q) >= CMP_W'(cap_q)) || (occ_q == OCC_W'(DEPTH));
	assign empty       = (occ_q == '0);
	assign scan_end    = (idx_q == occ_q);
	assign hit         = (rdata_q == cmd_q.key_value);
	assign at_rear     = (idx_inc >= occ_q);
	assign del_noneigh = cmd_q.after ? at_rear : (idx_q == '0);
	assign open_end    = (idx_q == slot_q);

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign removed_value = out_removed_q;
	assign entry_count   = out_count_q;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				case (cmd_q.kind)
					K_DEQ: begin
						state_d = empty ? S_RESP : S_CLOSE_RD0;
					end
					K_INS: begin
						state_d = (empty || full) ? S_RESP : S_SCAN_RD;
					end
					K_DEL: begin
						state_d = empty ? S_RESP : S_SCAN_RD;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_SCAN_RD: begin
				state_d = scan_end ? S_RESP : S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (!hit) begin
					state_d = S_SCAN_RD;
				end else if (cmd_q.kind == K_INS) begin
					state_d = S_OPEN_RD;
				end else begin
					state_d = del_noneigh ? S_RESP : S_CLOSE_RD0;
				end
			end
			S_OPEN_RD: begin
				state_d = open_end ? S_RESP : S_OPEN_WR;
			end
			S_OPEN_WR: begin
				state_d = S_OPEN_RD;
			end
			S_CLOSE_RD0: begin
				state_d = S_CLOSE_CAP;
			end
			S_CLOSE_CAP: begin
				state_d = S_CLOSE_RD;
			end
			S_CLOSE_RD: begin
				state_d = at_rear ? S_RESP : S_CLOSE_WR;
			end
			S_CLOSE_WR: begin
				state_d = S_CLOSE_RD;
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Memory port and handshake controls of the sequencer.
	always_comb begin
		cmd_ready = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
			end
			S_CHECK: begin
				if (cmd_q.kind == K_ENQ && !full) begin
					mem_we    = 1'b1;
					mem_waddr = occ_q[ADDR_W-1:0];
					mem_wdata = cmd_q.key_value;
				end
			end
			S_SCAN_RD: begin
				if (!scan_end) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[ADDR_W-1:0];
				end
			end
			S_OPEN_RD: begin
				if (open_end) begin
					mem_we    = 1'b1;
					mem_waddr = slot_q[ADDR_W-1:0];
					mem_wdata = cmd_q.ins_value;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_dec[ADDR_W-1:0];
				end
			end
			S_OPEN_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[ADDR_W-1:0];
				mem_wdata = rdata_q;
			end
			S_CLOSE_RD0: begin
				mem_re    = 1'b1;
				mem_raddr = slot_q[ADDR_W-1:0];
			end
			S_CLOSE_RD: begin
				if (!at_rear) begin
					mem_re    = 1'b1;
					mem_raddr = idx_inc[ADDR_W-1:0];
				end
			end
			S_CLOSE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[ADDR_W-1:0];
				mem_wdata = rdata_q;
			end
			S_RESP: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	// Control registers: state, capacity, occupancy and the result beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				cap_q <= capacity_limit;
			end
			if ((state_q == S_CHECK && cmd_q.kind == K_ENQ && !full) ||
			    (state_q == S_OPEN_RD && open_end)) begin
				occ_q <= occ_q + 1'b1;
			end else if (state_q == S_CLOSE_RD && at_rear) begin
				occ_q <= occ_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command, indices and pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q     <= cmd;
					status_q  <= ST_OK;
					removed_q <= '0;
				end
			end
			S_CHECK: begin
				case (cmd_q.kind)
					K_ENQ: begin
						if (full) begin
							status_q <= ST_FULL;
						end
					end
					K_DEQ: begin
						if (empty) begin
							status_q <= ST_EMPTY;
						end
						slot_q <= '0;
					end
					K_INS: begin
						if (empty) begin
							status_q <= ST_EMPTY;
						end else if (full) begin
							status_q <= ST_FULL;
						end
						idx_q <= '0;
					end
					K_DEL: begin
						if (empty) begin
							status_q <= ST_EMPTY;
						end
						idx_q <= '0;
					end
					default: begin
					end
				endcase
			end
			S_SCAN_RD: begin
				if (scan_end) begin
					status_q <= ST_NOTFOUND;
				end
			end
			S_SCAN_CMP: begin
				if (!hit) begin
					idx_q <= idx_inc;
				end else if (cmd_q.kind == K_INS) begin
					slot_q <= cmd_q.after ? idx_inc : idx_q;
					idx_q  <= occ_q;
				end else if (del_noneigh) begin
					status_q <= ST_NONEIGH;
				end else begin
					slot_q <= cmd_q.after ? idx_inc : idx_dec;
				end
			end
			S_OPEN_WR: begin
				idx_q <= idx_dec;
			end
			S_CLOSE_CAP: begin
				removed_q <= rdata_q;
				idx_q     <= slot_q;
			end
			S_CLOSE_WR: begin
				idx_q <= idx_inc;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_count_q   <= CNT_W'(occ_q);
		end
	end

	// List memory: one write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

endmodule
